@@ hdl/sactl_pkg.sv @@
// ----------------------------------------------------------------------------
// sactl_pkg
// Shared types and constants of the set-associative tag store with LRU
// replacement: beat payloads, line layout, CSR map and reset values.
// ----------------------------------------------------------------------------
package sactl_pkg;

   localparam int DEF_MAX_SETS = 256;
   localparam int DEF_WAYS     = 8;

   // CSR map, register index = paddr[3:2]
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_SET_INDEX_BITS    = 2'd0;
   localparam logic [1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS_IN_USE       = 2'd2;

   localparam logic [3:0] RST_SET_INDEX_BITS    = 4'd8;
   localparam logic [4:0] RST_BLOCK_OFFSET_BITS = 5'd4;
   localparam logic [3:0] RST_WAYS_IN_USE       = 4'd8;

   typedef struct packed {
      logic [3:0] set_index_bits;
      logic [4:0] block_offset_bits;
      logic [3:0] ways_in_use;
   } cfg_type;

   typedef struct packed {
      logic [31:0] address;
      logic        is_read;
      logic        dirty_value;
      logic [30:0] access_stamp;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  way;
      logic [7:0]  set_number;
      logic [31:0] tag_value;
      logic        victim_valid;
      logic        victim_dirty;
      logic [31:0] victim_tag;
   } rsp_type;

   // one line of the tag store
   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic [31:0] tag;
      logic [30:0] stamp;
   } line_type;

endpackage

@@ hdl/sactl_regs.sv @@
// ----------------------------------------------------------------------------
// sactl_regs
// APB-style configuration registers: set index bits, block offset bits and
// ways in use. Zero wait states, writes in the access phase.
// ----------------------------------------------------------------------------
module sactl_regs
   import sactl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_beat;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_beat = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (reg_idx)
            REG_SET_INDEX_BITS:    cfg_in.set_index_bits    = pwdata[3:0];
            REG_BLOCK_OFFSET_BITS: cfg_in.block_offset_bits = pwdata[4:0];
            REG_WAYS_IN_USE:       cfg_in.ways_in_use       = pwdata[3:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_index_bits    <= RST_SET_INDEX_BITS;
         cfg_ff.block_offset_bits <= RST_BLOCK_OFFSET_BITS;
         cfg_ff.ways_in_use       <= RST_WAYS_IN_USE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SET_INDEX_BITS:    prdata = {28'd0, cfg_ff.set_index_bits};
         REG_BLOCK_OFFSET_BITS: prdata = {27'd0, cfg_ff.block_offset_bits};
         REG_WAYS_IN_USE:       prdata = {28'd0, cfg_ff.ways_in_use};
         default:               prdata = 32'd0;
      endcase
   end

endmodule

@@ hdl/sactl_store.sv @@
// ----------------------------------------------------------------------------
// sactl_store
// Tag store memory: one row per set holding all ways. Synchronous read, one
// row write per cycle except during the clearing sweep after reset.
// ----------------------------------------------------------------------------
module sactl_store
   import sactl_pkg::*;
#(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int WAYS     = DEF_WAYS,
   parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [SET_W-1:0]      addr,
   input  line_type [WAYS-1:0]   wdata,
   output line_type [WAYS-1:0]   rdata,
   output logic                  busy
);

   line_type [WAYS-1:0] mem [MAX_SETS];
   line_type [WAYS-1:0] rd_ff;
   logic                clr_active_ff;
   logic                clr_active_in;
   logic [SET_W-1:0]    clr_cnt_ff;
   logic [SET_W-1:0]    clr_cnt_in;

   assign rdata = rd_ff;
   assign busy  = clr_active_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == SET_W'(MAX_SETS - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

endmodule

@@ hdl/set_assoc_cache_tag_lru.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// Set-associative cache tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req_payload) takes one access beat:
//    address, read/write flag, dirty value and time stamp.
//  - rsp channel (rsp_valid/rsp_ready/rsp_payload) returns one beat per
//    access: hit, way, set, tag and the prior state of a replaced line.
//  - CSR port (APB style, pready tied high) holds the address split and the
//    ways in use; write it only while no access is in flight.
// Timing:
//  - One access at a time. Accept edge reads the set row, the LOOK state
//    compares all ways in parallel, and the WRITE state writes the row back
//    and loads the response register.
//  - A miss on a set with every searched way valid, with more than one way
//    in use, adds a serial stamp scan, one way per cycle.
// Reset:
//  - State, rsp_valid and CSR registers reset, and the store runs a clearing
//    sweep, one row per cycle; req_ready stays low until it is done.
// Stall:
//  - A held response parks the next access at its write-back step; the row
//    is written only once the response register frees up.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru
   import sactl_pkg::*;
#(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int WAYS     = DEF_WAYS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int MAX_SB   = $clog2(MAX_SETS + 1) - 1;  // floor(log2(MAX_SETS))
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NW_W     = $clog2(WAYS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_WRITE
   } state_type;

   cfg_type             cfg;
   line_type [WAYS-1:0] row;
   line_type [WAYS-1:0] wrow;
   logic                store_busy;
   logic                mem_rd;
   logic                mem_wr;
   logic [SET_W-1:0]    mem_addr;

   // effective config
   logic [4:0]          sb_eff;
   logic [5:0]          tag_shift;
   logic [31:0]         set_full;
   logic [31:0]         req_tag;
   logic [NW_W-1:0]     nw_eff;
   logic [WAY_W-1:0]    nw_last;

   // lookup
   logic                any_hit;
   logic                any_free;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic                req_beat;
   logic                rsp_free;
   logic [31:0]         way_ext;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [SET_W-1:0]    set_idx_ff, set_idx_in;
   logic [7:0]          set_num_ff, set_num_in;
   logic [31:0]         tag_ff, tag_in;
   logic                is_read_ff, is_read_in;
   logic                dval_ff, dval_in;
   logic [30:0]         stamp_ff, stamp_in;
   logic                hit_ff, hit_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic [WAY_W-1:0]    idx_ff, idx_in;
   logic [30:0]         best_ff, best_in;

   sactl_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sactl_store #(
      .MAX_SETS (MAX_SETS),
      .WAYS     (WAYS),
      .SET_W    (SET_W)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .rd_en (mem_rd),
      .wr_en (mem_wr),
      .addr  (mem_addr),
      .wdata (wrow),
      .rdata (row),
      .busy  (store_busy)
   );

   // address split; set index bits clamp to what the store holds
   always_comb begin
      if (32'(cfg.set_index_bits) > MAX_SB) begin
         sb_eff = 5'(MAX_SB);
      end else begin
         sb_eff = {1'b0, cfg.set_index_bits};
      end
      tag_shift = {1'b0, cfg.block_offset_bits} + {1'b0, sb_eff};
      set_full  = (req_payload.address >> cfg.block_offset_bits)
                  & ~(32'hFFFF_FFFF << sb_eff);
      req_tag   = (tag_shift >= 6'd32) ? 32'd0 : (req_payload.address >> tag_shift);
   end

   // ways in use: zero acts as one, above WAYS acts as WAYS
   always_comb begin
      if (cfg.ways_in_use == 4'd0) begin
         nw_eff = NW_W'(1);
      end else if (32'(cfg.ways_in_use) > WAYS) begin
         nw_eff = NW_W'(WAYS);
      end else begin
         nw_eff = NW_W'(cfg.ways_in_use);
      end
      nw_last = WAY_W'(nw_eff - 1'b1);
   end

   // parallel tag compare, lowest way wins
   always_comb begin
      any_hit  = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (i < 32'(nw_eff)) begin
            if (row[i].valid && (row[i].tag == tag_ff)) begin
               any_hit = 1'b1;
               hit_way = WAY_W'(i);
            end
            if (!row[i].valid) begin
               any_free = 1'b1;
               free_way = WAY_W'(i);
            end
         end
      end
   end

   assign req_beat  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !store_busy;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign mem_rd    = req_beat;
   assign mem_wr    = (state_ff == ST_WRITE) && rsp_free;
   assign mem_addr  = (state_ff == ST_IDLE) ? set_full[SET_W-1:0] : set_idx_ff;
   assign way_ext   = 32'(way_ff);

   // updated row for write-back
   always_comb begin
      wrow = row;
      if (hit_ff) begin
         wrow[way_ff].stamp = stamp_ff;
         if (!is_read_ff) begin
            wrow[way_ff].dirty = dval_ff;
         end
      end else begin
         wrow[way_ff].valid = 1'b1;
         wrow[way_ff].dirty = is_read_ff ? 1'b0 : dval_ff;
         wrow[way_ff].tag   = tag_ff;
         wrow[way_ff].stamp = stamp_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      set_idx_in   = set_idx_ff;
      set_num_in   = set_num_ff;
      tag_in       = tag_ff;
      is_read_in   = is_read_ff;
      dval_in      = dval_ff;
      stamp_in     = stamp_ff;
      hit_in       = hit_ff;
      way_in       = way_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               set_idx_in = set_full[SET_W-1:0];
               set_num_in = set_full[7:0];
               tag_in     = req_tag;
               is_read_in = req_payload.is_read;
               dval_in    = req_payload.dirty_value;
               stamp_in   = req_payload.access_stamp;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hit_in  = any_hit;
            idx_in  = WAY_W'(1);
            best_in = row[0].stamp;
            if (any_hit) begin
               way_in   = hit_way;
               state_in = ST_WRITE;
            end else if (any_free) begin
               way_in   = free_way;
               state_in = ST_WRITE;
            end else if (nw_last == '0) begin
               way_in   = '0;
               state_in = ST_WRITE;
            end else begin
               way_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // oldest stamp, strict compare keeps the lower way on ties
            if (row[idx_ff].stamp < best_ff) begin
               best_in = row[idx_ff].stamp;
               way_in  = idx_ff;
            end
            if (idx_ff == nw_last) begin
               state_in = ST_WRITE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.hit         = hit_ff;
               rsp_in.way         = way_ext[2:0];
               rsp_in.set_number  = set_num_ff;
               rsp_in.tag_value   = tag_ff;
               if (hit_ff) begin
                  rsp_in.victim_valid = 1'b0;
                  rsp_in.victim_dirty = 1'b0;
                  rsp_in.victim_tag   = 32'd0;
               end else begin
                  rsp_in.victim_valid = row[way_ff].valid;
                  rsp_in.victim_dirty = row[way_ff].dirty;
                  rsp_in.victim_tag   = row[way_ff].valid ? row[way_ff].tag : 32'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff     <= rsp_in;
      set_idx_ff <= set_idx_in;
      set_num_ff <= set_num_in;
      tag_ff     <= tag_in;
      is_read_ff <= is_read_in;
      dval_ff    <= dval_in;
      stamp_ff   <= stamp_in;
      hit_ff     <= hit_in;
      way_ff     <= way_in;
      idx_ff     <= idx_in;
      best_ff    <= best_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/sactl_chk.sv @@
// ----------------------------------------------------------------------------
// sactl_chk
// Port-level checks of the tag store, bound to the top level.
// ----------------------------------------------------------------------------
module sactl_chk
   import sactl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   // reset starts the clearing sweep: nothing taken, nothing shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   // one access in flight: no back-to-back accepts
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second access taken while one is in flight");

   // a hit reports no victim
   a_hit_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.hit |->
         !rsp_payload.victim_valid && !rsp_payload.victim_dirty
         && (rsp_payload.victim_tag == 32'd0))
      else $error("victim fields set on a hit");

   // an empty victim line carries no dirty bit or tag
   a_empty_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.victim_valid |->
         !rsp_payload.victim_dirty && (rsp_payload.victim_tag == 32'd0))
      else $error("invalid victim line reports dirty or tag");

endmodule

bind set_assoc_cache_tag_lru sactl_chk u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
